/* src/etl_pkg.sv */
// ----------------------------------------------------------------------------
// Euler tour LCA package
// Shared item types, command codes and queue entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package etl_pkg;

    localparam int VAL_W = 8;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_BUILD = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam logic RES_BUILD = 1'b0;
    localparam logic RES_QUERY = 1'b1;

    typedef struct packed {
        logic [1:0]       kind;
        logic [VAL_W-1:0] entry_value;
        logic             first_visit;
        logic [VAL_W-1:0] node_a;
        logic [VAL_W-1:0] node_b;
    } in_item_t;

    typedef struct packed {
        logic             result_kind;
        logic [VAL_W-1:0] ancestor;
        logic             error;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_QUERY = 2'd2
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [VAL_W-1:0] value;
        logic             first;
        logic [VAL_W-1:0] node_a;
        logic [VAL_W-1:0] node_b;
        logic             value_ok;
        logic             a_ok;
        logic             b_ok;
    } cmd_t;

endpackage

`default_nettype wire

/* src/euler_tour_sparse_table_lca.sv */
// ----------------------------------------------------------------------------
// Euler tour LCA top level
// Load: taken in the executor's idle state. Query: two first-position reads and two
// table reads on single ports. Build: a read and a write per tour entry, then two
// reads and a write per table entry filled; one word at a time in the executor
// behind a two-word queue. Reset clears control state only, no RAM pass.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_tour_sparse_table_lca #(
    parameter int MAX_NODES    = 256,
    parameter int TOUR_DEPTH   = 512,
    parameter int TABLE_LEVELS = 10
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire etl_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output etl_pkg::out_item_t      m_data
);

    logic          q_valid;
    logic          q_pop;
    etl_pkg::cmd_t q_cmd;

    etl_front #(.MAX_NODES(MAX_NODES)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
    );

    etl_back #(
        .MAX_NODES(MAX_NODES), .TOUR_DEPTH(TOUR_DEPTH), .TABLE_LEVELS(TABLE_LEVELS)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // A recognised word that is taken must be waiting in the queue afterwards.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.kind != etl_pkg::KIND_SPARE) |=> q_valid)
        else $error("accepted word missing from queue");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.error |-> m_data.ancestor == '0)
        else $error("error result carries an ancestor");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.result_kind == etl_pkg::RES_BUILD) |-> m_data.ancestor == '0)
        else $error("build result carries an ancestor");

endmodule

`default_nettype wire

/* src/etl_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module etl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata_reg
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/etl_front.sv */
// ----------------------------------------------------------------------------
// Euler tour LCA front end
// Accepts input words, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module etl_front #(
    parameter int MAX_NODES = 256
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire etl_pkg::in_item_t s_data,
    output logic                  q_valid,
    output etl_pkg::cmd_t         q_cmd,
    input  wire logic             q_pop
);

    etl_pkg::cmd_t fifo_reg [2];
    logic          wr_ptr_reg, wr_ptr_next;
    logic          rd_ptr_reg, rd_ptr_next;
    logic [1:0]    count_reg, count_next;
    etl_pkg::cmd_t cmd;
    logic          push;
    logic          known;

    always_comb begin
        known          = 1'b1;
        cmd.op         = etl_pkg::OP_LOAD;
        case (s_data.kind)
            etl_pkg::KIND_LOAD:  cmd.op = etl_pkg::OP_LOAD;
            etl_pkg::KIND_BUILD: cmd.op = etl_pkg::OP_BUILD;
            etl_pkg::KIND_QUERY: cmd.op = etl_pkg::OP_QUERY;
            default:             known  = 1'b0;
        endcase
        cmd.value    = s_data.entry_value;
        cmd.first    = s_data.first_visit;
        cmd.node_a   = s_data.node_a;
        cmd.node_b   = s_data.node_b;
        cmd.value_ok = 32'(s_data.entry_value) < 32'(MAX_NODES);
        cmd.a_ok     = 32'(s_data.node_a) < 32'(MAX_NODES);
        cmd.b_ok     = 32'(s_data.node_b) < 32'(MAX_NODES);
    end

    // Words of the unused kind are taken and dropped here.
    assign s_ready = count_reg != 2'd2;
    assign push    = s_valid && s_ready && known;
    assign q_valid = count_reg != 2'd0;
    assign q_cmd   = fifo_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ (q_pop && q_valid);
        count_next  = count_reg + 2'(push) - 2'(q_pop && q_valid);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= cmd;
        end
    end

endmodule

`default_nettype wire

/* src/etl_back.sv */
// ----------------------------------------------------------------------------
// Euler tour LCA back end
// Executes loads, sparse table builds and ancestor queries over three RAMs.
// ----------------------------------------------------------------------------
`default_nettype none

module etl_back #(
    parameter int MAX_NODES    = 256,
    parameter int TOUR_DEPTH   = 512,
    parameter int TABLE_LEVELS = 10
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               q_valid,
    input  wire etl_pkg::cmd_t      q_cmd,
    output logic                    q_pop,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output etl_pkg::out_item_t      m_data
);

    localparam int PW = $clog2(TOUR_DEPTH);
    localparam int LW = $clog2(TOUR_DEPTH + 1);
    localparam int NW = $clog2(MAX_NODES);
    localparam int KW = $clog2(TABLE_LEVELS);
    localparam int TD = TABLE_LEVELS * TOUR_DEPTH;
    localparam int TW = $clog2(TD);
    localparam int VW = etl_pkg::VAL_W;

    typedef enum logic [13:0] {
        ST_IDLE  = 14'b00000000000001,
        ST_B0_RD = 14'b00000000000010,
        ST_B0_WR = 14'b00000000000100,
        ST_BK_RX = 14'b00000000001000,
        ST_BK_RY = 14'b00000000010000,
        ST_BK_WR = 14'b00000000100000,
        ST_Q_RA  = 14'b00000001000000,
        ST_Q_RB  = 14'b00000010000000,
        ST_Q_POS = 14'b00000100000000,
        ST_Q_LVL = 14'b00001000000000,
        ST_Q_RX  = 14'b00010000000000,
        ST_Q_RY  = 14'b00100000000000,
        ST_Q_MIN = 14'b01000000000000,
        ST_OUT   = 14'b10000000000000
    } state_t;

    state_t             state_reg, state_next;
    logic [LW-1:0]      len_reg, len_next;
    logic               ready_reg, ready_next;
    logic               ovf_reg, ovf_next;
    logic               m_valid_reg, m_valid_next;
    etl_pkg::out_item_t m_data_reg, m_data_next;
    etl_pkg::out_item_t res_reg, res_next;
    logic [PW-1:0]      s_reg, s_next;
    logic [KW-1:0]      k_reg, k_next;
    logic [LW:0]        span_reg, span_next;
    logic [TW-1:0]      base_prev_reg, base_prev_next;
    logic [TW-1:0]      base_cur_reg, base_cur_next;
    logic [VW-1:0]      a_reg, a_next, b_reg, b_next;
    logic [PW-1:0]      pa_reg, pa_next;
    logic [PW-1:0]      lo_reg, lo_next, hi_reg, hi_next;
    logic [VW-1:0]      x_reg, x_next;

    logic               tour_we, fp_we, tbl_we;
    logic [PW-1:0]      tour_raddr;
    logic [VW-1:0]      tour_rdata;
    logic [NW-1:0]      fp_waddr, fp_raddr;
    logic [PW-1:0]      fp_rdata;
    logic [TW-1:0]      tbl_waddr, tbl_raddr, q_base;
    logic [VW-1:0]      tbl_wdata, tbl_rdata, pair_min;
    logic [PW-1:0]      lo_w, hi_w;
    logic [LW-1:0]      range_len;
    int                 lg;

    etl_ram #(.WIDTH(VW), .DEPTH(TOUR_DEPTH)) u_tour (
        .aclk(aclk), .we(tour_we), .waddr(PW'(len_reg)), .wdata(q_cmd.value),
        .raddr(tour_raddr), .rdata_reg(tour_rdata)
    );

    etl_ram #(.WIDTH(PW), .DEPTH(MAX_NODES)) u_first_pos (
        .aclk(aclk), .we(fp_we), .waddr(fp_waddr), .wdata(PW'(len_reg)),
        .raddr(fp_raddr), .rdata_reg(fp_rdata)
    );

    etl_ram #(.WIDTH(VW), .DEPTH(TD)) u_minima (
        .aclk(aclk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
        .raddr(tbl_raddr), .rdata_reg(tbl_rdata)
    );

    assign q_pop   = (state_reg == ST_IDLE) && q_valid;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign pair_min   = (x_reg < tbl_rdata) ? x_reg : tbl_rdata;
    assign tour_we    = q_pop && (q_cmd.op == etl_pkg::OP_LOAD)
                        && (32'(len_reg) < 32'(TOUR_DEPTH));
    assign fp_we      = tour_we && q_cmd.first && q_cmd.value_ok;
    assign fp_waddr   = NW'(q_cmd.value);
    assign fp_raddr   = (state_reg == ST_Q_RA) ? NW'(a_reg) : NW'(b_reg);
    assign tour_raddr = s_reg;
    assign tbl_we     = (state_reg == ST_B0_WR) || (state_reg == ST_BK_WR);
    assign tbl_waddr  = (state_reg == ST_B0_WR) ? TW'(s_reg) : base_cur_reg + TW'(s_reg);
    assign tbl_wdata  = (state_reg == ST_B0_WR) ? tour_rdata : pair_min;
    assign q_base     = TW'(k_reg) * TW'(TOUR_DEPTH);

    always_comb begin
        case (state_reg)
            ST_BK_RX: tbl_raddr = base_prev_reg + TW'(s_reg);
            ST_BK_RY: tbl_raddr = base_prev_reg + TW'(s_reg) + TW'(span_reg >> 1);
            ST_Q_RX:  tbl_raddr = q_base + TW'(lo_reg);
            ST_Q_RY:  tbl_raddr = q_base + TW'(hi_reg) + TW'(1) - (TW'(1) << k_reg);
            default:  tbl_raddr = '0;
        endcase
    end

    // Order the two first positions and measure the span between them.
    assign lo_w      = (pa_reg <= fp_rdata) ? pa_reg : fp_rdata;
    assign hi_w      = (pa_reg <= fp_rdata) ? fp_rdata : pa_reg;
    assign range_len = LW'(hi_reg) - LW'(lo_reg) + LW'(1);

    always_comb begin
        lg = 0;
        for (int i = 0; i < LW; i++) begin
            if (range_len[i]) begin
                lg = i;
            end
        end
        if (lg > TABLE_LEVELS - 1) begin
            lg = TABLE_LEVELS - 1;
        end
    end

    always_comb begin
        state_next     = state_reg;
        len_next       = len_reg;
        ready_next     = ready_reg;
        ovf_next       = ovf_reg;
        res_next       = res_reg;
        s_next         = s_reg;
        k_next         = k_reg;
        span_next      = span_reg;
        base_prev_next = base_prev_reg;
        base_cur_next  = base_cur_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        pa_next        = pa_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        x_next         = x_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    case (q_cmd.op)
                        etl_pkg::OP_LOAD: begin
                            if (tour_we) begin
                                len_next   = len_reg + LW'(1);
                                ready_next = 1'b0;
                            end else begin
                                ovf_next = 1'b1;
                            end
                        end
                        etl_pkg::OP_BUILD: begin
                            res_next = '{etl_pkg::RES_BUILD, '0,
                                         (len_reg == '0) || ovf_reg};
                            if (len_reg == '0) begin
                                ready_next = 1'b0;
                                state_next = ST_OUT;
                            end else begin
                                s_next     = '0;
                                state_next = ST_B0_RD;
                            end
                        end
                        etl_pkg::OP_QUERY: begin
                            a_next = q_cmd.node_a;
                            b_next = q_cmd.node_b;
                            if (!ready_reg || ovf_reg || !q_cmd.a_ok || !q_cmd.b_ok) begin
                                res_next   = '{etl_pkg::RES_QUERY, '0, 1'b1};
                                state_next = ST_OUT;
                            end else begin
                                state_next = ST_Q_RA;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_B0_RD: state_next = ST_B0_WR;
            ST_B0_WR: begin
                if (32'(s_reg) + 32'd1 < 32'(len_reg)) begin
                    s_next     = s_reg + PW'(1);
                    state_next = ST_B0_RD;
                end else if (32'(len_reg) < 32'd2 || TABLE_LEVELS < 2) begin
                    ready_next = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    k_next         = KW'(1);
                    span_next      = (LW + 1)'(2);
                    s_next         = '0;
                    base_prev_next = '0;
                    base_cur_next  = TW'(TOUR_DEPTH);
                    state_next     = ST_BK_RX;
                end
            end
            ST_BK_RX: state_next = ST_BK_RY;
            ST_BK_RY: begin
                x_next     = tbl_rdata;
                state_next = ST_BK_WR;
            end
            ST_BK_WR: begin
                if (32'(s_reg) + 32'd1 + 32'(span_reg) <= 32'(len_reg)) begin
                    s_next     = s_reg + PW'(1);
                    state_next = ST_BK_RX;
                end else if (32'(k_reg) + 32'd1 >= 32'(TABLE_LEVELS)
                             || 32'(span_reg) * 32'd2 > 32'(len_reg)) begin
                    ready_next = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    k_next         = k_reg + KW'(1);
                    span_next      = span_reg << 1;
                    s_next         = '0;
                    base_prev_next = base_cur_reg;
                    base_cur_next  = base_cur_reg + TW'(TOUR_DEPTH);
                    state_next     = ST_BK_RX;
                end
            end
            ST_Q_RA: state_next = ST_Q_RB;
            ST_Q_RB: begin
                pa_next    = fp_rdata;
                state_next = ST_Q_POS;
            end
            ST_Q_POS: begin
                lo_next = lo_w;
                hi_next = hi_w;
                if (32'(hi_w) >= 32'(len_reg)) begin
                    res_next   = '{etl_pkg::RES_QUERY, '0, 1'b1};
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_Q_LVL;
                end
            end
            ST_Q_LVL: begin
                k_next     = KW'(lg);
                state_next = ST_Q_RX;
            end
            ST_Q_RX: state_next = ST_Q_RY;
            ST_Q_RY: begin
                x_next     = tbl_rdata;
                state_next = ST_Q_MIN;
            end
            ST_Q_MIN: begin
                res_next   = '{etl_pkg::RES_QUERY, pair_min, 1'b0};
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            ready_reg   <= 1'b0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            ready_reg   <= ready_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg    <= m_data_next;
        res_reg       <= res_next;
        s_reg         <= s_next;
        k_reg         <= k_next;
        span_reg      <= span_next;
        base_prev_reg <= base_prev_next;
        base_cur_reg  <= base_cur_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        pa_reg        <= pa_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        x_reg         <= x_next;
    end

endmodule

`default_nettype wire
